>>> rtl/delayed_event_slot_table_core_defines.svh
// Assertion macros for the delayed event slot table core.
// Used by the top level only; they expand to nothing when SYNTHESIS is defined.
`ifndef DELAYED_EVENT_SLOT_TABLE_CORE_DEFINES_SVH
`define DELAYED_EVENT_SLOT_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define DEST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define DEST_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEST_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEST_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/dest_pkg.sv
// Shared types, codes and helper functions of the delayed event slot table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package dest_pkg;

  // Item kinds on the input channel.
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SINK_FULL = 2'd3;

  // Most results one tick may release, and the wait reported for an empty table.
  localparam logic [3:0]  MAX_OUT = 4'd8;
  localparam logic [31:0] NO_WAIT = 32'hFFFF_FFFF;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 144;

  // Command strobes from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan_rd;
    logic commit;
    logic emit_rd;
    logic load_single;
    logic load_slot;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic is_tick;
    logic has_release;
    logic emit_last;
    logic out_free;
  } ctrl_stat_t;

  // Keeps the bytes below n of a little-endian 64-bit payload.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/delayed_event_slot_table_core.sv
// Top level of the delayed event slot table: controller plus datapath.
// Depends on dest_pkg, dest_ctrl, dest_dp, dest_ram and the assertion macro header.
//
// Usage. The input stream carries one item per word: in_tuser is the item kind
// (0 schedules a delayed event, 1 is a tick that releases due events) and in_tdata
// holds the time, event fields, delay and accept limit. The output stream gives
// one or more result words per item; out_tlast marks the final one, out_tuser says
// that the word carries a released event, and out_tdata holds the event fields,
// the status code and the nearest remaining wait.
// Operation. Every item is handled by one pass over the slot store, one slot per
// cycle through the single read port of the slot RAM. After the scan the item is
// committed, and an item that gives one result then loads it into the output
// register. A tick that releases events reads each released event back from the
// slot RAM before it is presented. A new item is accepted only once the previous
// one has presented its last result.
// Stalls. A presented result sits in the output register until the receiver takes
// it; the block keeps its state meanwhile and waits. The next item may be accepted
// while the last result of the previous one is still waiting to be taken.
// Reset. rst_n is synchronous and active low; it frees every slot and empties the
// output register. Slot contents need no clearing because the scan ignores free slots.
`default_nettype none
`include "delayed_event_slot_table_core_defines.svh"

module delayed_event_slot_table_core #(
  parameter int SLOTS         = 8,
  parameter int PAYLOAD_BYTES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // Low bit up: now_time[31:0], task_id[39:32], context_id[71:40],
  // pay_len[75:72], payload_data[139:76], delay_time[171:140],
  // accept_limit[175:172].
  input  wire logic [dest_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd: 0 schedule, 1 tick.
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // Low bit up: out_task[7:0], out_context[39:8], out_len[43:40],
  // out_payload[107:44], status[109:108], next_wait[141:110], zero padding[143:142].
  output logic      [dest_pkg::OUT_DATA_W-1:0] out_tdata,
  // released: the word carries an event.
  output logic                                 out_tuser,
  // last_result: final word caused by the item.
  output logic                                 out_tlast
);

  dest_pkg::ctrl_cmd_t  cmd;
  dest_pkg::ctrl_stat_t stat;
  logic [5:0]           cmd_vec;

  dest_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dest_dp #(
    .SLOTS         (SLOTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign cmd_vec = {cmd.start, cmd.scan_rd, cmd.commit, cmd.emit_rd,
                    cmd.load_single, cmd.load_slot};

  // Once an item is taken, no other is taken until its results are out.
  `DEST_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "item accepted while busy")
  // The controller never overwrites a result that has not been taken.
  `DEST_ASSERT(a_no_overwrite, clk, rst_n, (cmd.load_single || cmd.load_slot) |-> stat.out_free, "pending result overwritten")
  // At most one command strobe per cycle.
  `DEST_ASSERT(a_one_command, clk, rst_n, $onehot0(cmd_vec), "several commands in one cycle")
  // Reset empties the output register.
  `DEST_ASSERT_NR(a_reset_empties_output, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

`default_nettype wire

>>> rtl/dest_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing; used for the slot store of the delayed event table.
`default_nettype none

module dest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dest_ctrl.sv
// Sequencing state machine of the delayed event slot table.
// Depends on dest_pkg for the command and status structs.
`default_nettype none

module dest_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire dest_pkg::ctrl_stat_t stat,
  output dest_pkg::ctrl_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_COMMIT  = 3'd3;
  localparam logic [2:0] S_SINGLE  = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_LD = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // The last slot read is evaluated here.
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (stat.is_tick && stat.has_release) begin
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.load_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.load_slot = 1'b1;
          state_nxt     = stat.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dest_dp.sv
// Datapath of the delayed event slot table: item register, slot store,
// scan accumulators, release list and output register. Depends on dest_pkg and dest_ram.
`default_nettype none

module dest_dp #(
  parameter int SLOTS         = 8,
  parameter int PAYLOAD_BYTES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [dest_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [dest_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  input  wire dest_pkg::ctrl_cmd_t                 cmd,
  output dest_pkg::ctrl_stat_t                     stat
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PAY_W  = 8 * PAYLOAD_BYTES;
  localparam int WORD_W = 76 + PAY_W;
  localparam logic [3:0] PB_LEN = 4'(PAYLOAD_BYTES);

  // Item register.
  logic        cmd_r;
  logic [31:0] now_r;
  logic [7:0]  task_r;
  logic [31:0] ctx_r;
  logic [3:0]  len_r;
  logic [63:0] pay_r;
  logic [31:0] delay_r;
  logic [3:0]  lim_r;

  // Scan and release bookkeeping.
  logic [SLOTS-1:0] used_r;
  logic [IDX_W-1:0] addr_r;
  logic             proc_valid_r;
  logic [IDX_W-1:0] proc_idx_r;
  logic [31:0]      best_r;
  logic             found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             free_found_r;
  logic             sink_r;
  logic [3:0]       n_r;
  logic [IDX_W-1:0] list_r [8];
  logic [2:0]       k_r;

  // Output register.
  logic        out_valid_r;
  logic        out_rel_r;
  logic [7:0]  out_task_r;
  logic [31:0] out_ctx_r;
  logic [3:0]  out_len_r;
  logic [63:0] out_pay_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_wait_r;
  logic        out_last_r;

  // Slot store.
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [7:0]  rd_task;
  logic [31:0] rd_ctx;
  logic [3:0]  rd_len;
  logic [PAY_W-1:0] rd_pay;
  logic [31:0] rd_due;
  logic [31:0] elapsed;
  logic [31:0] remain;
  logic [31:0] remain_c;
  logic        p_used;
  logic        due_hit;
  logic        do_release;
  logic        hit_limit;
  logic        take_min;
  logic        store_ok;
  logic [31:0] new_wait;
  logic [3:0]  len_sat;
  logic [63:0] pay_store;
  logic [63:0] pay_now;
  logic [1:0]  single_status;
  logic [31:0] wait_val;
  logic        out_free;

  dest_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_task = ram_rdata[7:0];
  assign rd_ctx  = ram_rdata[39:8];
  assign rd_len  = ram_rdata[43:40];
  assign rd_pay  = ram_rdata[44 +: PAY_W];
  assign rd_due  = ram_rdata[44 + PAY_W +: 32];

  // Wrap-safe compare: the slot is due when now - due is not negative.
  assign elapsed  = now_r - rd_due;
  assign remain   = rd_due - now_r;
  assign remain_c = remain[31] ? 32'd0 : remain;
  assign p_used   = used_r[proc_idx_r];
  assign due_hit  = proc_valid_r && (cmd_r == dest_pkg::CMD_TICK) && p_used &&
                    !elapsed[31] && !sink_r;
  assign do_release = due_hit && (n_r < lim_r);
  assign hit_limit  = due_hit && !(n_r < lim_r);
  assign take_min   = proc_valid_r && p_used && !do_release;

  assign store_ok  = (cmd_r == dest_pkg::CMD_SCHEDULE) && (delay_r != 32'd0) &&
                     (len_r <= PB_LEN) && free_found_r;
  assign new_wait  = delay_r[31] ? 32'd0 : delay_r;
  assign len_sat   = (len_r > PB_LEN) ? PB_LEN : len_r;
  assign pay_store = pay_r & dest_pkg::byte_mask(len_r);
  assign pay_now   = pay_r & dest_pkg::byte_mask(len_sat);
  assign ram_we    = cmd.commit && store_ok;
  assign ram_wdata = {now_r + delay_r, pay_store[PAY_W-1:0], len_r, ctx_r, task_r};
  assign ram_re    = cmd.scan_rd || cmd.emit_rd;
  assign ram_raddr = cmd.emit_rd ? list_r[k_r] : addr_r;

  always_comb begin
    single_status = dest_pkg::ST_OK;
    if (cmd_r == dest_pkg::CMD_TICK) begin
      single_status = sink_r ? dest_pkg::ST_SINK_FULL : dest_pkg::ST_OK;
    end else if (delay_r == 32'd0) begin
      single_status = dest_pkg::ST_OK;
    end else if (len_r > PB_LEN) begin
      single_status = dest_pkg::ST_TOO_LONG;
    end else if (!free_found_r) begin
      single_status = dest_pkg::ST_FULL;
    end
  end

  assign wait_val = found_r ? best_r : dest_pkg::NO_WAIT;
  assign out_free = !out_valid_r || out_tready;

  assign stat.scan_last   = (addr_r == IDX_W'(SLOTS - 1));
  assign stat.is_tick     = (cmd_r == dest_pkg::CMD_TICK);
  assign stat.has_release = (n_r != 4'd0);
  assign stat.emit_last   = ((4'(k_r) + 4'd1) == n_r);
  assign stat.out_free    = out_free;

  // Item capture; payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r   <= in_tuser;
      now_r   <= in_tdata[31:0];
      task_r  <= in_tdata[39:32];
      ctx_r   <= in_tdata[71:40];
      len_r   <= in_tdata[75:72];
      pay_r   <= in_tdata[139:76];
      delay_r <= in_tdata[171:140];
      lim_r   <= (in_tdata[175:172] > dest_pkg::MAX_OUT) ? dest_pkg::MAX_OUT
                                                           : in_tdata[175:172];
    end
  end

  // Scan accumulators and slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      addr_r       <= '0;
      proc_valid_r <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      sink_r       <= 1'b0;
      n_r          <= '0;
      k_r          <= '0;
    end else begin
      proc_valid_r <= cmd.scan_rd;
      if (cmd.start) begin
        addr_r       <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        sink_r       <= 1'b0;
        n_r          <= '0;
        k_r          <= '0;
      end
      if (cmd.scan_rd) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (do_release) begin
        used_r[proc_idx_r] <= 1'b0;
        n_r                <= n_r + 4'd1;
      end
      if (hit_limit) begin
        sink_r <= 1'b1;
      end
      if (take_min && (!found_r || (remain_c < best_r))) begin
        found_r <= 1'b1;
      end
      if (proc_valid_r && !p_used && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (cmd.commit && store_ok) begin
        used_r[free_idx_r] <= 1'b1;
        found_r            <= 1'b1;
      end
      if (cmd.load_slot) begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  // Data side of the scan: indices, running minimum and release list.
  always_ff @(posedge clk) begin
    proc_idx_r <= addr_r;
    if (take_min && (!found_r || (remain_c < best_r))) begin
      best_r <= remain_c;
    end
    if (proc_valid_r && !p_used && !free_found_r) begin
      free_idx_r <= proc_idx_r;
    end
    if (do_release) begin
      list_r[n_r[2:0]] <= proc_idx_r;
    end
    if (cmd.commit && store_ok && (!found_r || (new_wait < best_r))) begin
      best_r <= new_wait;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_single || cmd.load_slot) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_wait_r <= wait_val;
      out_last_r <= 1'b1;
      if ((cmd_r == dest_pkg::CMD_SCHEDULE) && (delay_r == 32'd0)) begin
        out_rel_r    <= 1'b1;
        out_task_r   <= task_r;
        out_ctx_r    <= ctx_r;
        out_len_r    <= len_sat;
        out_pay_r    <= pay_now;
        out_status_r <= dest_pkg::ST_OK;
      end else begin
        out_rel_r    <= 1'b0;
        out_task_r   <= '0;
        out_ctx_r    <= '0;
        out_len_r    <= '0;
        out_pay_r    <= '0;
        out_status_r <= single_status;
      end
    end else if (cmd.load_slot) begin
      out_rel_r    <= 1'b1;
      out_task_r   <= rd_task;
      out_ctx_r    <= rd_ctx;
      out_len_r    <= rd_len;
      out_pay_r    <= 64'(rd_pay);
      out_status_r <= (stat.emit_last && sink_r) ? dest_pkg::ST_SINK_FULL
                                                 : dest_pkg::ST_OK;
      out_wait_r   <= wait_val;
      out_last_r   <= stat.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rel_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_wait_r, out_status_r, out_pay_r, out_len_r,
                       out_ctx_r, out_task_r};

endmodule

`default_nettype wire
